// ===== src/fsb_pkg.sv =====
// fsb_pkg: shared widths, register indexes and reset values for the
// Floyd-Steinberg binarizer core. No dependencies.
`timescale 1ns / 1ps

package fsb_pkg;

  localparam int PIX_BITS       = 8;
  localparam int LW_BITS        = 11;
  localparam int THR_BITS       = 8;
  localparam int CFG_DATA_BITS  = 11;
  localparam int CFG_IDX_BITS   = 1;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int ERROR_BITS_DEF = 10;

  // register indexes on the config port
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD  = 1'd1;

  localparam logic [LW_BITS-1:0]  LINE_WIDTH_RST = 11'd800;
  localparam logic [THR_BITS-1:0] THRESHOLD_RST  = 8'd128;

  // output level of a white pixel
  localparam int WHITE_LEVEL = 255;

endpackage

// ===== src/floyd_steinberg_binarizer_core.sv =====
// floyd_steinberg_binarizer_core: Floyd-Steinberg error-diffusion binarizer,
// one pixel in, one black/white decision out. Depends on fsb_pkg.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload
// --------  ---  -----------------  ------------------------------------
// in_       in   in_valid/in_ready  in_pixel[7:0], in_frame_start
// out_      out  out_valid/out_ready out_white
// cfg_      in   cfg_we (no wait)   cfg_index (0 line_width, 1 threshold),
//                                   cfg_data[10:0]
//
// Throughput is one pixel per clock while the output is not stalled, set by the
// read-modify-write loop on the row error memory: the entry is read at accept
// and updated by a later write, forwarded through the bypass register. A pixel
// passes the stage-1 registers and then the result register before out_valid rises.
// Reset is synchronous (rst_n low) and needs no clearing pass: the first row of
// a frame never reads the memory. A stalled output holds the pipeline, and a
// new pixel is still taken while the result register is being emptied.

module floyd_steinberg_binarizer_core #(
  parameter int MAX_WIDTH  = fsb_pkg::MAX_WIDTH_DEF,
  parameter int ERROR_BITS = fsb_pkg::ERROR_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel input
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fsb_pkg::PIX_BITS-1:0]       in_pixel,
  input  logic                               in_frame_start,
  // decision output
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_white,
  // config write port
  input  logic                               cfg_we,
  input  logic [fsb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [fsb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import fsb_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;  // column bits
  localparam int WW = (CW + 1 > LW_BITS) ? CW + 1 : LW_BITS;     // width compare
  localparam int EB = ERROR_BITS;
  localparam int XW = EB + 3;                                    // working width

  localparam logic signed [XW-1:0] SAT_HI = XW'((1 << (EB - 1)) - 1);
  localparam logic signed [XW-1:0] SAT_LO = -SAT_HI - XW'(1);
  localparam logic signed [XW-1:0] WHITE_X = XW'(WHITE_LEVEL);

  function automatic logic signed [EB-1:0] sat(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[EB-1:0];
  endfunction

  // ---------------------------------------------------------------- config
  logic [LW_BITS-1:0]  cfg_line_width_r;
  logic [THR_BITS-1:0] cfg_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_line_width_r <= LINE_WIDTH_RST;
      cfg_threshold_r  <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: cfg_line_width_r <= cfg_data[LW_BITS-1:0];
        REG_THRESHOLD:  cfg_threshold_r  <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // last column index; zero width acts as one, oversize clamps to MAX_WIDTH
  logic [WW-1:0] lw_ext;
  logic [CW-1:0] last_col;

  always_comb begin
    lw_ext = WW'(cfg_line_width_r);
    if (lw_ext == '0)
      last_col = '0;
    else if (lw_ext > WW'(MAX_WIDTH))
      last_col = CW'(MAX_WIDTH - 1);
    else
      last_col = CW'(lw_ext - WW'(1));
  end

  // ------------------------------------------------------------ memory
  logic signed [EB-1:0] row_mem [MAX_WIDTH];

  // ---------------------------------------------------------- handshake
  logic s1_valid_r;
  logic out_valid_r, out_white_r;
  logic adv, fire, in_accept;

  assign adv       = !out_valid_r || out_ready;
  assign fire      = s1_valid_r && adv;
  assign in_ready  = !s1_valid_r || adv;
  assign in_accept = in_valid && in_ready;

  assign out_valid = out_valid_r;
  assign out_white = out_white_r;

  // --------------------------------------------------- stage 1: address
  logic [CW-1:0] col_r;
  logic          first_row_r;
  logic [CW-1:0] a_col;
  logic          a_first, a_last;

  assign a_col   = in_frame_start ? '0 : col_r;
  assign a_first = in_frame_start || first_row_r;
  assign a_last  = (a_col >= last_col);

  logic [PIX_BITS-1:0]  s1_pix_r;
  logic                 s1_start_r, s1_last_r, s1_first_r;
  logic [CW-1:0]        s1_col_r;
  logic signed [EB-1:0] mem_q_r;
  logic                 byp_r;
  logic signed [EB-1:0] byp_data_r;

  // ---------------------------------------------------- stage 2: update
  logic signed [EB-1:0] rc_r, pbl_r, pbm_r;
  logic                 hold_valid_r;
  logic [CW-1:0]        hold_addr_r;
  logic signed [EB-1:0] hold_data_r;

  logic signed [EB-1:0] stored, rc_eff, pbl_eff, pbm_eff;
  logic signed [EB-1:0] incoming, value;
  logic signed [XW-1:0] err, q;
  logic signed [EB-1:0] below_left, pbl_new, rc_new, pbm_new;
  logic                 white;

  always_comb begin
    // a last-column entry still in the hold register is newer than both
    // the memory word and the bypass copy (single-pixel rows hit this)
    stored   = s1_first_r ? '0 :
               (hold_valid_r && (hold_addr_r == s1_col_r)) ? hold_data_r :
               (byp_r ? byp_data_r : mem_q_r);
    rc_eff   = s1_start_r ? '0 : rc_r;
    pbl_eff  = s1_start_r ? '0 : pbl_r;
    pbm_eff  = s1_start_r ? '0 : pbm_r;
    incoming = sat(XW'(stored) + XW'(rc_eff));
    value    = sat($signed({{(XW-PIX_BITS){1'b0}}, s1_pix_r}) + XW'(incoming));
    white    = XW'(value) > $signed({{(XW-THR_BITS){1'b0}}, cfg_threshold_r});
    err      = XW'(value) - (white ? WHITE_X : '0);
    q        = err >>> 4;                        // floor divide by 16
    below_left = sat(XW'(pbl_eff) + (q <<< 1) + q);          // 3/16
    pbl_new    = sat(XW'(pbm_eff) + (q <<< 2) + q);          // 5/16
    rc_new     = sat((q <<< 3) - q);                         // 7/16
    pbm_new    = sat(q);                                     // 1/16
  end

  // write port: lower-left share now, last-column entry from the hold register once the port is free
  logic                 wa_en, wr_en;
  logic [CW-1:0]        wr_addr;
  logic signed [EB-1:0] wr_data;

  assign wa_en   = fire && (s1_col_r != '0);
  assign wr_en   = wa_en || hold_valid_r;
  assign wr_addr = wa_en ? (s1_col_r - CW'(1)) : hold_addr_r;
  assign wr_data = wa_en ? below_left : hold_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) row_mem[wr_addr] <= wr_data;
    if (in_accept) mem_q_r <= row_mem[a_col];
  end

  // ---------------------------------------------------------- registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      col_r        <= '0;
      first_row_r  <= 1'b1;
      rc_r         <= '0;
      pbl_r        <= '0;
      pbm_r        <= '0;
      hold_valid_r <= 1'b0;
      byp_r        <= 1'b0;
    end else begin
      if (in_accept) begin
        col_r       <= a_last ? '0 : a_col + CW'(1);
        first_row_r <= a_last ? 1'b0 : a_first;
        s1_valid_r  <= 1'b1;
      end else if (fire) begin
        s1_valid_r  <= 1'b0;
      end

      // forward a write that lands on the entry stage 1 read or holds
      if (in_accept)
        byp_r <= wr_en && (wr_addr == a_col);
      else if (s1_valid_r && wr_en && (wr_addr == s1_col_r))
        byp_r <= 1'b1;

      if (fire) begin
        if (s1_last_r) begin
          rc_r  <= '0;
          pbl_r <= '0;
          pbm_r <= '0;
        end else begin
          rc_r  <= rc_new;
          pbl_r <= pbl_new;
          pbm_r <= pbm_new;
        end
      end

      if (fire && s1_last_r)
        hold_valid_r <= 1'b1;
      else if (hold_valid_r && !wa_en)
        hold_valid_r <= 1'b0;

      if (adv) out_valid_r <= fire;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r   <= in_pixel;
      s1_start_r <= in_frame_start;
      s1_col_r   <= a_col;
      s1_last_r  <= a_last;
      s1_first_r <= a_first;
    end
    if (in_accept ? (wr_en && (wr_addr == a_col))
                  : (s1_valid_r && wr_en && (wr_addr == s1_col_r)))
      byp_data_r <= wr_data;
    if (fire && s1_last_r) begin
      hold_addr_r <= s1_col_r;
      hold_data_r <= pbl_new;
    end
    if (fire) out_white_r <= white;
  end

endmodule

// ===== tb/floyd_steinberg_binarizer_core_test.sv =====
// Self-checking testbench for floyd_steinberg_binarizer_core: directed table,
// then random phases of pixels checked against an error-diffusion predictor.
// Depends on fsb_pkg and the core RTL only.
`timescale 1ns / 1ps

module floyd_steinberg_binarizer_core_test;
  import fsb_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item moving on either side
  localparam int SETTLE_CYCLES  = 3;     // margin for the row memory write behind the last decision
  localparam int RAND_PHASES    = 10;
  localparam int BIG_PHASE      = 9;     // one full 1024-pixel row plus a few
  localparam int CALM_PHASE     = 5;     // long stretch with no idling on either side

  localparam int ERR_W  = ERROR_BITS_DEF;
  localparam int MAX_W  = MAX_WIDTH_DEF;
  localparam int ERR_HI = (1 << (ERR_W - 1)) - 1;
  localparam int ERR_LO = -(1 << (ERR_W - 1));

  // ---------------------------------------------------------------------------
  // DUT hookup
  // ---------------------------------------------------------------------------
  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     in_valid       = 1'b0;
  logic                     in_ready;
  logic [PIX_BITS-1:0]      in_pixel       = '0;
  logic                     in_frame_start = 1'b0;
  logic                     out_valid;
  logic                     out_ready      = 1'b0;
  logic                     out_white;
  logic                     cfg_we         = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index      = REG_LINE_WIDTH;
  logic [CFG_DATA_BITS-1:0] cfg_data       = '0;

  floyd_steinberg_binarizer_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_white      (out_white),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Directed table. Pixel rows with typed = 1 carry a decision that is obvious
  // from the threshold alone (no diffused error yet); all other pixel rows are
  // checked against the predictor. Config rows wait for the core to drain.
  // ---------------------------------------------------------------------------
  typedef enum bit {PIX_ROW, CFG_ROW} row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    logic [PIX_BITS-1:0]      pix;
    logic                     fs;
    logic                     typed;
    logic                     white;
  } stim_row_t;

  localparam int DIR_ROWS = 35;

  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    // reset config: width 800, threshold 128
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b1, 1'b1, 1'b1},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd0,   1'b0, 1'b1, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd128, 1'b1, 1'b1, 1'b0},  // equal is black
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd129, 1'b1, 1'b1, 1'b1},
    // top threshold: even full white stays black
    '{CFG_ROW, REG_THRESHOLD,  11'd255,  8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b1, 1'b1, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd254, 1'b0, 1'b0, 1'b0},
    // zero threshold: anything above zero is white
    '{CFG_ROW, REG_THRESHOLD,  11'd0,    8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd0,   1'b1, 1'b1, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd1,   1'b1, 1'b1, 1'b1},
    // two-pixel row: both edges every other pixel, rows below read back
    '{CFG_ROW, REG_THRESHOLD,  11'd128,  8'd0,   1'b0, 1'b0, 1'b0},
    '{CFG_ROW, REG_LINE_WIDTH, 11'd2,    8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd200, 1'b1, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd50,  1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd100, 1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd180, 1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd0,   1'b0, 1'b0, 1'b0},
    // width 0 behaves as 1: every pixel is first and last of its row
    '{CFG_ROW, REG_LINE_WIDTH, 11'd0,    8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b1, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd10,  1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd200, 1'b0, 1'b0, 1'b0},
    // shrink the width mid-row: column 3 becomes the last column
    '{CFG_ROW, REG_LINE_WIDTH, 11'd5,    8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd90,  1'b1, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd160, 1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd70,  1'b0, 1'b0, 1'b0},
    '{CFG_ROW, REG_LINE_WIDTH, 11'd2,    8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd230, 1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd20,  1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd140, 1'b0, 1'b0, 1'b0},
    // all-white input at the top threshold: the first pixel stays black and
    // its positive error pushes the pixels after it over the threshold
    '{CFG_ROW, REG_THRESHOLD,  11'd255,  8'd0,   1'b0, 1'b0, 1'b0},
    '{CFG_ROW, REG_LINE_WIDTH, 11'd2,    8'd0,   1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b1, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0},
    '{PIX_ROW, REG_LINE_WIDTH, 11'd0,    8'd255, 1'b0, 1'b0, 1'b0}
  };

  // ---------------------------------------------------------------------------
  // Predictor state: shadow registers and the diffusion accumulators
  // ---------------------------------------------------------------------------
  logic [LW_BITS-1:0]      width_reg = LINE_WIDTH_RST;
  logic [THR_BITS-1:0]     thr_reg   = THRESHOLD_RST;
  logic signed [ERR_W-1:0] row_err [MAX_W];
  bit                      row_err_set [MAX_W];   // entry written at least once
  logic signed [ERR_W-1:0] carry_right = '0;
  logic signed [ERR_W-1:0] below_left  = '0;
  logic signed [ERR_W-1:0] below_mid   = '0;
  int                      col         = 0;
  bit                      top_row     = 1'b1;

  logic white_expected [$];   // decisions still owed by the core
  int   errors       = 0;
  int   stall_cycles = 0;
  bit   calm         = 1'b0;  // suppresses idling on both sides

  function automatic logic signed [ERR_W-1:0] clamp_err(int v);
    if (v > ERR_HI) return ERR_W'(ERR_HI);
    if (v < ERR_LO) return ERR_W'(ERR_LO);
    return ERR_W'(v);
  endfunction

  // One pixel through the diffusion; updates state, returns the decision.
  function automatic logic dither_pixel(logic [PIX_BITS-1:0] pix, logic fs);
    int   eff_w, c, incoming, level, resid, q;
    logic is_white, at_end;
    eff_w = int'(width_reg);
    if (eff_w == 0) eff_w = 1;
    if (eff_w > MAX_W) eff_w = MAX_W;
    if (fs) begin
      carry_right = '0;
      below_left  = '0;
      below_mid   = '0;
      col         = 0;
      top_row     = 1'b1;
    end
    c        = col;
    at_end   = (c >= eff_w - 1);
    incoming = top_row ? 0 : int'(row_err[c]);
    incoming = clamp_err(incoming + carry_right);
    level    = clamp_err(int'(pix) + incoming);
    is_white = level > int'(thr_reg);
    resid    = level - (is_white ? WHITE_LEVEL : 0);
    q        = resid >>> 4;   // floor divide by 16
    if (c > 0) begin
      row_err[c-1]     = clamp_err(below_left + 3 * q);
      row_err_set[c-1] = 1'b1;
    end
    below_left = clamp_err(below_mid + 5 * q);
    if (at_end) begin
      // right and lower-right shares fall off the frame edge
      row_err[c]     = below_left;
      row_err_set[c] = 1'b1;
      carry_right    = '0;
      below_left     = '0;
      below_mid      = '0;
      col            = 0;
      top_row        = 1'b0;
    end else begin
      carry_right = clamp_err(7 * q);
      below_mid   = clamp_err(q);
      col         = c + 1;
    end
    return is_white;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Everything changes on the falling edge.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic fs,
                            input logic typed, input logic typed_white);
    logic start, predicted;
    // A row that grew past what the previous row wrote would read stale
    // memory; restart the frame instead.
    start     = fs || (!top_row && !row_err_set[col]);
    predicted = dither_pixel(pix, start);
    while (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_pixel       <= pix;
    in_frame_start <= start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    white_expected.push_back(typed ? typed_white : predicted);
    @(negedge clk);
  endtask

  // Drop valid and wait until every owed decision is out and the row memory
  // write behind the last pixel has landed.
  task automatic settle();
    in_valid <= 1'b0;
    while (white_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LINE_WIDTH: width_reg = val;
      REG_THRESHOLD:  thr_reg   = val[THR_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Output side backpressure, off during the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  // ---------------------------------------------------------------------------
  // Checker: each decision against the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (white_expected.size() == 0) begin
        $display("%0t: out_white unexpected: expected none, got %0b", $time, out_white);
        errors++;
      end else if (out_white !== white_expected[0]) begin
        $display("%0t: out_white mismatch: expected %0b, got %0b",
                 $time, white_expected[0], out_white);
        errors++;
        void'(white_expected.pop_front());
      end else begin
        void'(white_expected.pop_front());
      end
    end
  end

  // Watchdog: any cycle where an item moves on either side restarts the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int                 i, phase, k, n, mode, base;
    logic [LW_BITS-1:0] w;
    logic [7:0]         thr;
    logic [7:0]         pix;
    logic               fs;

    // hold reset, then release it
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].kind == CFG_ROW) begin
        settle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
      end else begin
        send_pixel(DIRECTED[i].pix, DIRECTED[i].fs, DIRECTED[i].typed, DIRECTED[i].white);
      end
    end

    // Random phases: new width and threshold each time, image content drawn
    // from a few textures so that error builds up the way it does on real
    // images. Phases that open without a frame start change width mid-row.
    for (phase = 0; phase < RAND_PHASES; phase++) begin
      settle();
      case (phase % 6)
        3:       w = '0;
        4:       w = 11'd1;
        default: w = ($urandom_range(3) == 0) ? LW_BITS'($urandom_range(130, 25))
                                              : LW_BITS'($urandom_range(24, 2));
      endcase
      if (phase == BIG_PHASE) w = '1;   // above MAX_WIDTH, caps at 1024
      case (phase % 5)
        0:       thr = 8'd0;
        1:       thr = 8'd255;
        default: thr = 8'($urandom_range(255));
      endcase
      write_reg(REG_LINE_WIDTH, w);
      write_reg(REG_THRESHOLD, {3'b000, thr});

      calm = (phase == CALM_PHASE);
      n    = (phase == BIG_PHASE) ? MAX_W + 6 : (calm ? 150 : $urandom_range(70, 30));
      mode = (phase == BIG_PHASE) ? 0 : $urandom_range(3);
      base = $urandom_range(255);

      for (k = 0; k < n; k++) begin
        case (mode)
          0: pix = 8'($urandom_range(255));
          1: pix = $urandom_range(1) ? 8'(255 - $urandom_range(2)) : 8'($urandom_range(2));
          2: pix = 8'(base) ^ 8'($urandom_range(7));   // flat gray with noise
          default: pix = 8'(base + k * 5);             // wrapping ramp
        endcase
        fs = (k == 0) ? ($urandom_range(9) < 6) : ($urandom_range(199) == 0);
        send_pixel(pix, fs, 1'b0, 1'b0);
      end
      calm = 1'b0;
    end

    settle();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
